// ===== sv/deq_pkg.sv =====
// Shared types, codes and index helpers for the double-ended queue unit.
// No dependencies; used by deq_ram and double_ended_queue_unit.
`default_nettype none

package deq_pkg;

  // Ring size and derived widths.
  localparam int DEPTH   = 64;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 7;
  localparam int OUT_DATA_W = 104;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [OCC_W-1:0]  occ_t;
  typedef logic [WORD_W-1:0] word_t;

  // Requested operation.
  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  // Result status.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Step a ring index forward with wrap.
  function automatic idx_t idx_inc(input idx_t i);
    if (i == IDX_W'(DEPTH - 1)) begin
      return '0;
    end
    return i + IDX_W'(1);
  endfunction

  // Step a ring index backward with wrap.
  function automatic idx_t idx_dec(input idx_t i);
    if (i == '0) begin
      return IDX_W'(DEPTH - 1);
    end
    return i - IDX_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== sv/deq_ram.sv =====
// Ring store of the double-ended queue: one write port, one registered read port.
// Depends on deq_pkg for the depth and word types.
`default_nettype none

module deq_ram (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire deq_pkg::idx_t waddr_i,
  input  wire deq_pkg::word_t wdata_i,
  input  wire logic          re_i,
  input  wire deq_pkg::idx_t raddr_i,
  output deq_pkg::word_t     rdata_o
);
  import deq_pkg::*;

  word_t mem_q [DEPTH];
  word_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/double_ended_queue_unit.sv =====
// Double-ended queue of signed 32-bit words over a 64-entry ring store.
// Uses deq_pkg and deq_ram.
`default_nettype none

// Usage:
//   Requests arrive on the s_axis channel: tuser carries the operation
//   (push front, push back, pop front, pop back), tdata the word to push.
//   Each request yields exactly one result on the m_axis channel: tuser
//   carries the status, tdata the popped word, the entry count, the empty
//   flag and the front and back words after the operation.
//   The front and back words are held in registers, so pushes and pops that
//   leave at most one word finish without touching the memory read port:
//   their result goes straight into the output register, and such requests
//   can be taken every cycle while the receiver does not stall. A pop that
//   leaves two or more words reads the next end word from the ring store
//   through its registered read port, so its result is loaded only after
//   that read, and the unit takes no new request until the result is loaded.
//   Reset empties the queue at once; the ring store is not cleared, since
//   an entry is only ever read after a push wrote it.
//   While the receiver stalls a result, the unit holds it in the output
//   register and accepts no further request until that slot frees up.
module double_ended_queue_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Request channel.
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,  // [31:0] push_value
  input  wire logic [1:0]   s_axis_tuser,  // [1:0] cmd
  // Result channel.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] pop_value, [38:32] entry_count, [39] is_empty,
  // [71:40] front_value, [103:72] back_value
  output logic [103:0]      m_axis_tdata,
  output logic [1:0]        m_axis_tuser   // [1:0] status
);
  import deq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WAIT = 1'b1;

  logic    state_q, state_d;
  idx_t    head_q, head_d;
  idx_t    tail_q, tail_d;
  occ_t    occ_q, occ_d;
  word_t   front_q, front_d;
  word_t   back_q, back_d;
  word_t   popped_q, popped_d;
  logic    pend_front_q, pend_front_d;

  logic    out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  status_e out_stat_q, out_stat_d;

  logic    in_fire, out_free, out_load;
  logic    ram_we, ram_re;
  idx_t    ram_waddr, ram_raddr;
  word_t   ram_rdata;
  word_t   push_word, popped_v;
  status_e stat_v;
  cmd_e    cmd;
  logic    is_full, is_empty_v;

  assign cmd       = cmd_e'(s_axis_tuser);
  assign push_word = s_axis_tdata;
  assign is_full   = (occ_q == OCC_W'(DEPTH));
  assign out_free  = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  deq_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (push_word),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Operation sequencing: update pointers, issue memory accesses, form result.
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    occ_d        = occ_q;
    front_d      = front_q;
    back_d       = back_q;
    popped_d     = popped_q;
    pend_front_d = pend_front_q;
    ram_we       = 1'b0;
    ram_waddr    = head_q;
    ram_re       = 1'b0;
    ram_raddr    = head_q;
    out_load     = 1'b0;
    popped_v     = '0;
    stat_v       = STAT_OK;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_load = 1'b1;
          case (cmd)
            CMD_PUSH_FRONT: begin
              if (is_full) begin
                stat_v = STAT_FULL;
              end else begin
                head_d    = idx_dec(head_q);
                ram_we    = 1'b1;
                ram_waddr = head_d;
                occ_d     = occ_q + OCC_W'(1);
                front_d   = push_word;
                if (occ_q == '0) begin
                  back_d = push_word;
                end
              end
            end
            CMD_PUSH_BACK: begin
              if (is_full) begin
                stat_v = STAT_FULL;
              end else begin
                tail_d    = idx_inc(tail_q);
                ram_we    = 1'b1;
                ram_waddr = tail_d;
                occ_d     = occ_q + OCC_W'(1);
                back_d    = push_word;
                if (occ_q == '0) begin
                  front_d = push_word;
                end
              end
            end
            CMD_POP_FRONT: begin
              if (occ_q == '0) begin
                stat_v = STAT_EMPTY;
              end else begin
                popped_v = front_q;
                popped_d = front_q;
                head_d   = idx_inc(head_q);
                occ_d    = occ_q - OCC_W'(1);
                if (occ_q == OCC_W'(2)) begin
                  front_d = back_q;
                end else if (occ_q > OCC_W'(2)) begin
                  // The new front word must come from the ring store.
                  ram_re       = 1'b1;
                  ram_raddr    = head_d;
                  pend_front_d = 1'b1;
                  state_d      = S_WAIT;
                  out_load     = 1'b0;
                end
              end
            end
            CMD_POP_BACK: begin
              if (occ_q == '0) begin
                stat_v = STAT_EMPTY;
              end else begin
                popped_v = back_q;
                popped_d = back_q;
                tail_d   = idx_dec(tail_q);
                occ_d    = occ_q - OCC_W'(1);
                if (occ_q == OCC_W'(2)) begin
                  back_d = front_q;
                end else if (occ_q > OCC_W'(2)) begin
                  // The new back word must come from the ring store.
                  ram_re       = 1'b1;
                  ram_raddr    = tail_d;
                  pend_front_d = 1'b0;
                  state_d      = S_WAIT;
                  out_load     = 1'b0;
                end
              end
            end
            default: begin
              stat_v = STAT_OK;
            end
          endcase
        end
      end
      S_WAIT: begin
        // Read data is held by the memory until the output slot frees.
        if (out_free) begin
          popped_v = popped_q;
          if (pend_front_q) begin
            front_d = ram_rdata;
          end else begin
            back_d = ram_rdata;
          end
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result packing; empty views read zero.
  assign is_empty_v = (occ_d == '0);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_stat_d  = out_stat_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_stat_d  = stat_v;
      out_data_d  = {(is_empty_v ? word_t'(0) : back_d),
                     (is_empty_v ? word_t'(0) : front_d),
                     is_empty_v,
                     COUNT_W'(occ_d),
                     popped_v};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      tail_q       <= IDX_W'(DEPTH - 1);
      occ_q        <= '0;
      pend_front_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      occ_q        <= occ_d;
      pend_front_q <= pend_front_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    front_q    <= front_d;
    back_q     <= back_d;
    popped_q   <= popped_d;
    out_data_q <= out_data_d;
    out_stat_q <= out_stat_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

`ifndef SYNTHESIS
  // Occupancy never exceeds the ring size.
  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(DEPTH))
    else $error("occupancy beyond ring depth");

  // An empty queue has its back index one step behind its head index.
  a_empty_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> (tail_q == idx_dec(head_q)))
    else $error("ring pointers inconsistent on empty queue");

  // Entering the wait state always comes with a ring store read.
  a_wait_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && state_d == S_WAIT) |-> ram_re)
    else $error("wait state without memory read");

  // Occupancy only changes when a request was accepted.
  a_occ_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(occ_q))
    else $error("occupancy changed without a request");

  // A pending pop holds back new requests and keeps the memory unwritten.
  a_wait_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |-> (!ram_we && !in_fire))
    else $error("activity during pending pop");
`endif

endmodule

`default_nettype wire
